// ===== design/assert_macros.svh =====
// Shared assertion macros for the frame parser checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define SFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== design/sfp_pkg.sv =====
package sfp_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam int CSR_INDEX_W = 8;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // Configuration register indexes
   localparam csr_index_type CSR_SYNC_BYTE  = 8'd0;
   localparam csr_index_type CSR_FRAME_TYPE = 8'd1;

   localparam logic [7:0]  SYNC_RESET = 8'd170;
   localparam logic [7:0]  TYPE_RESET = 8'd1;
   localparam logic [15:0] HEADER_LEN = 16'd5;

   // One result to be finished by the back end
   typedef struct packed {
      logic [7:0]  channel;
      logic [15:0] sequence_num;
      logic [15:0] value;
      logic [14:0] index;
      logic        last;
      logic        empty;
   } item_type;

endpackage

// ===== design/sfp_front.sv =====
module sfp_front
   import sfp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                csr_valid,
   input  csr_index_type       csr_index,
   input  logic [7:0]          csr_data,
   input  logic                queue_full,
   output logic                push,
   output item_type            push_item
);

   localparam logic [3:0] PH_HUNT   = 4'd0;
   localparam logic [3:0] PH_TYPE   = 4'd1;
   localparam logic [3:0] PH_LEN_HI = 4'd2;
   localparam logic [3:0] PH_LEN_LO = 4'd3;
   localparam logic [3:0] PH_SKIP   = 4'd4;
   localparam logic [3:0] PH_CHAN   = 4'd5;
   localparam logic [3:0] PH_SEQ_HI = 4'd6;
   localparam logic [3:0] PH_SEQ_LO = 4'd7;
   localparam logic [3:0] PH_CNT_HI = 4'd8;
   localparam logic [3:0] PH_CNT_LO = 4'd9;
   localparam logic [3:0] PH_SMP_HI = 4'd10;
   localparam logic [3:0] PH_SMP_LO = 4'd11;

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  sync_ff, sync_in;
   logic [7:0]  dtype_ff, dtype_in;
   logic [7:0]  kind_ff, kind_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  chan_ff, chan_in;
   logic [15:0] seq_ff, seq_in;
   logic [15:0] count_ff, count_in;
   logic [14:0] pos_ff, pos_in;
   logic [7:0]  high_ff, high_in;

   logic        accept;
   logic [15:0] word;
   logic [17:0] expect_len;
   logic [15:0] remain;
   logic [15:0] pos_next;
   logic        last_smp;

   assign req_ready  = !queue_full;
   assign accept     = req_valid && req_ready;
   assign word       = {high_ff, req_data_byte};
   assign expect_len = 18'(HEADER_LEN) + {1'b0, word, 1'b0};
   assign remain     = length_ff - HEADER_LEN;
   assign pos_next   = {1'b0, pos_ff} + 16'd1;
   assign last_smp   = pos_next >= count_ff;

   always_comb begin
      sync_in  = sync_ff;
      dtype_in = dtype_ff;
      if (csr_valid) begin
         if (csr_index == CSR_SYNC_BYTE) begin
            sync_in = csr_data;
         end else if (csr_index == CSR_FRAME_TYPE) begin
            dtype_in = csr_data;
         end
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      length_in = length_ff;
      left_in   = left_ff;
      chan_in   = chan_ff;
      seq_in    = seq_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      high_in   = high_ff;
      push      = 1'b0;
      push_item.channel      = chan_ff;
      push_item.sequence_num = seq_ff;
      push_item.value        = word;
      push_item.index        = pos_ff;
      push_item.last         = last_smp;
      push_item.empty        = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_data_byte == sync_ff) begin
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               kind_in  = req_data_byte;
               phase_in = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               high_in  = req_data_byte;
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length_in = word;
               if (kind_ff != dtype_ff || word < HEADER_LEN) begin
                  // skip the whole payload of a foreign or short frame
                  left_in  = word;
                  phase_in = (word == 16'd0) ? PH_HUNT : PH_SKIP;
               end else begin
                  phase_in = PH_CHAN;
               end
            end
            PH_SKIP: begin
               left_in = left_ff - 16'd1;
               if (left_ff == 16'd1) begin
                  phase_in = PH_HUNT;
               end
            end
            PH_CHAN: begin
               chan_in  = req_data_byte;
               phase_in = PH_SEQ_HI;
            end
            PH_SEQ_HI: begin
               high_in  = req_data_byte;
               phase_in = PH_SEQ_LO;
            end
            PH_SEQ_LO: begin
               seq_in   = word;
               phase_in = PH_CNT_HI;
            end
            PH_CNT_HI: begin
               high_in  = req_data_byte;
               phase_in = PH_CNT_LO;
            end
            PH_CNT_LO: begin
               count_in = word;
               if (expect_len != {2'b00, length_ff}) begin
                  left_in  = remain;
                  phase_in = (remain == 16'd0) ? PH_HUNT : PH_SKIP;
               end else if (word == 16'd0) begin
                  // empty frame: one marker beat
                  push                = 1'b1;
                  push_item.value     = 16'd0;
                  push_item.index     = 15'd0;
                  push_item.last      = 1'b1;
                  push_item.empty     = 1'b1;
                  phase_in            = PH_HUNT;
               end else begin
                  pos_in   = 15'd0;
                  phase_in = PH_SMP_HI;
               end
            end
            PH_SMP_HI: begin
               high_in  = req_data_byte;
               phase_in = PH_SMP_LO;
            end
            PH_SMP_LO: begin
               push     = 1'b1;
               pos_in   = pos_next[14:0];
               phase_in = last_smp ? PH_HUNT : PH_SMP_HI;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         sync_ff   <= SYNC_RESET;
         dtype_ff  <= TYPE_RESET;
         kind_ff   <= 8'd0;
         length_ff <= 16'd0;
         left_ff   <= 16'd0;
         chan_ff   <= 8'd0;
         seq_ff    <= 16'd0;
         count_ff  <= 16'd0;
         pos_ff    <= 15'd0;
         high_ff   <= 8'd0;
      end else begin
         phase_ff  <= phase_in;
         sync_ff   <= sync_in;
         dtype_ff  <= dtype_in;
         kind_ff   <= kind_in;
         length_ff <= length_in;
         left_ff   <= left_in;
         chan_ff   <= chan_in;
         seq_ff    <= seq_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
         high_ff   <= high_in;
      end
   end

endmodule

// ===== design/sfp_queue.sv =====
module sfp_queue
   import sfp_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   item_type        slots_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_pop;

   assign full       = (count_ff == FullCnt);
   assign head_valid = (count_ff != '0);
   assign head_item  = slots_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/sfp_back.sv =====
module sfp_back
   import sfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  item_type    head_item,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_channel,
   output logic [15:0] rsp_sequence_res,
   output logic [15:0] rsp_sample_value,
   output logic [14:0] rsp_sample_index,
   output logic        rsp_frame_end,
   output logic        rsp_no_samples,
   output logic [31:0] rsp_drop_total
);

   logic        out_valid_ff, out_valid_in;
   item_type    out_item_ff;
   logic [31:0] out_drop_ff;
   logic        seen_ff, seen_in;
   logic [15:0] last_seq_ff, last_seq_in;
   logic [31:0] drop_ff, drop_in;

   logic [15:0] expected;
   logic [15:0] gap;
   logic [32:0] sum;
   logic [31:0] drop_closed;

   assign pop      = head_valid && (!out_valid_ff || rsp_ready);
   assign expected = last_seq_ff + 16'd1;
   assign gap      = head_item.sequence_num - expected;
   assign sum      = {1'b0, drop_ff} + {17'd0, gap};
   // saturate the drop total at all ones
   assign drop_closed = !seen_ff ? drop_ff : (sum[32] ? '1 : sum[31:0]);

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      seen_in      = seen_ff;
      last_seq_in  = last_seq_ff;
      drop_in      = drop_ff;
      if (pop) begin
         out_valid_in = 1'b1;
         if (head_item.last) begin
            seen_in     = 1'b1;
            last_seq_in = head_item.sequence_num;
            drop_in     = drop_closed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_item_ff <= head_item;
         out_drop_ff <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         seen_ff      <= 1'b0;
         last_seq_ff  <= 16'd0;
         drop_ff      <= 32'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         seen_ff      <= seen_in;
         last_seq_ff  <= last_seq_in;
         drop_ff      <= drop_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_channel      = out_item_ff.channel;
   assign rsp_sequence_res = out_item_ff.sequence_num;
   assign rsp_sample_value = out_item_ff.value;
   assign rsp_sample_index = out_item_ff.index;
   assign rsp_frame_end    = out_item_ff.last;
   assign rsp_no_samples   = out_item_ff.empty;
   assign rsp_drop_total   = out_drop_ff;

endmodule

// ===== design/sample_frame_stream_parser_top.sv =====
// Sample frame stream parser.
// req channel: one stream byte per beat (req_data_byte). Bytes are taken at
// one per clock while the internal queue has room.
// rsp channel: one beat per decoded sample, or one marker beat (no_samples
// set) for a frame with zero samples; frame_end flags a frame's last beat and
// drop_total already includes that frame's sequence-gap update.
// csr channel: csr_index 0 writes the sync byte (reset 0xAA), index 1 the
// data frame type (reset 1); other indexes are ignored. csr_ready is always
// high; write only while the block is idle.
// A result beat passes through the queue and the back end's output register
// to rsp. Throughput: one byte per cycle while the queue has room, set by
// the single-byte parse step of the front end; the back end retires one
// queue entry per cycle while rsp is not stalled.
// A stalled rsp holds its beat; the front keeps taking bytes until the
// queue between front and back fills, then drops req_ready.
// Reset (synchronous) returns to sync hunting, clears the sequence history
// and drop total, empties the queue and restores the register defaults.
module sample_frame_stream_parser_top
   import sfp_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_data_byte,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    rsp_channel,
   output logic [15:0]   rsp_sequence_res,
   output logic [15:0]   rsp_sample_value,
   output logic [14:0]   rsp_sample_index,
   output logic          rsp_frame_end,
   output logic          rsp_no_samples,
   output logic [31:0]   rsp_drop_total,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [7:0]    csr_data
);

   logic     push;
   item_type push_item;
   logic     queue_full;
   logic     pop;
   logic     head_valid;
   item_type head_item;

   assign csr_ready = 1'b1;

   sfp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .queue_full    (queue_full),
      .push          (push),
      .push_item     (push_item)
   );

   sfp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   sfp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_channel      (rsp_channel),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_sample_value (rsp_sample_value),
      .rsp_sample_index (rsp_sample_index),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_no_samples   (rsp_no_samples),
      .rsp_drop_total   (rsp_drop_total)
   );

endmodule

// ===== design/sfp_checker.sv =====
`include "assert_macros.svh"

module sfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_channel,
   input logic [15:0] rsp_sequence_res,
   input logic [15:0] rsp_sample_value,
   input logic [14:0] rsp_sample_index,
   input logic        rsp_frame_end,
   input logic        rsp_no_samples,
   input logic [31:0] rsp_drop_total
);

   logic [31:0] prev_drop_ff, prev_drop_in;
   logic [14:0] exp_idx_ff, exp_idx_in;
   logic        rsp_fire;

   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      prev_drop_in = prev_drop_ff;
      exp_idx_in   = exp_idx_ff;
      if (rsp_fire) begin
         prev_drop_in = rsp_drop_total;
         exp_idx_in   = rsp_frame_end ? 15'd0 : rsp_sample_index + 15'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_drop_ff <= 32'd0;
         exp_idx_ff   <= 15'd0;
      end else begin
         prev_drop_ff <= prev_drop_in;
         exp_idx_ff   <= exp_idx_in;
      end
   end

   // stalled beat holds
   `SFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_channel) && $stable(rsp_sequence_res) &&
      $stable(rsp_sample_value) && $stable(rsp_sample_index) &&
      $stable(rsp_frame_end) && $stable(rsp_no_samples) && $stable(rsp_drop_total))

   // marker beat closes its frame with zero sample fields
   `SFP_ASSERT_IMPLY(a_marker_shape, clock, reset, rsp_valid && rsp_no_samples,
      rsp_frame_end && rsp_sample_value == 16'd0 && rsp_sample_index == 15'd0)

   // drop total never goes back
   `SFP_ASSERT_IMPLY(a_drop_monotonic, clock, reset, rsp_valid,
      rsp_drop_total >= prev_drop_ff)

   // sample positions run from zero within each frame
   `SFP_ASSERT_IMPLY(a_index_order, clock, reset, rsp_valid,
      rsp_sample_index == exp_idx_ff)

endmodule

bind sample_frame_stream_parser_top sfp_checker u_sfp_checker (.*);
